@@ sv/evrm_pkg.sv @@
// Package for the windowed event rate meter.
// Holds the fixed field widths, the queue depth and the queue status type.
// No dependencies.
`default_nettype none

package evrm_pkg;

	localparam int IV_BITS     = 24;
	localparam int RATE_BITS   = 33;
	localparam int TOTAL_BITS  = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [IV_BITS-1:0] IV_RESET = 24'd1000000;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_status_t;

endpackage

`default_nettype wire

@@ sv/windowed_event_rate_meter.sv @@
// Top level of the windowed event rate meter.
// Instantiates evrm_front, evrm_queue and evrm_back; depends on evrm_pkg.
//
// Words arrive on the item channel (item_valid/item_ready) with a command
// and a microsecond timestamp. A count word updates the window counts and
// the running total in the cycle it is accepted and gives no result, so
// count words are taken one per cycle. A read word is snapshotted into a
// four-entry queue and gives one result word on the result channel
// (result_valid/result_ready) carrying the total and the rate estimate.
// The rate is worked out one bit per cycle by a shift-add multiplier
// followed by a restoring divider; reads that fall past two intervals,
// or whose divisor is zero, skip the arithmetic. Read words are served
// one at a time.
// When the receiver stalls, the result register holds its word, the queue
// fills, and item_ready then drops for read words only; count words still
// flow. The interval register is written through cfg_we/cfg_wdata with no
// wait. Reset clears all counts, the window start and the queue, and sets
// the interval to one second.
`default_nettype none

module windowed_event_rate_meter
	import evrm_pkg::*;
#(
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [IV_BITS-1:0]    cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic                  cmd,
	input  wire logic [TIME_BITS-1:0]  now_us,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic [TOTAL_BITS-1:0]      total_count,
	output logic [RATE_BITS-1:0]       rate_per_interval
);

	localparam int QW = TOTAL_BITS + 2 * COUNT_BITS + IV_BITS + TIME_BITS;

	q_status_t             q_status;
	logic                  push;
	logic                  pop;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	logic [TOTAL_BITS-1:0] in_total;
	logic [COUNT_BITS-1:0] in_cur;
	logic [COUNT_BITS-1:0] in_prev;
	logic [IV_BITS-1:0]    in_iv;
	logic [TIME_BITS-1:0]  in_elapsed;
	logic [TOTAL_BITS-1:0] out_total;
	logic [COUNT_BITS-1:0] out_cur;
	logic [COUNT_BITS-1:0] out_prev;
	logic [IV_BITS-1:0]    out_iv;
	logic [TIME_BITS-1:0]  out_elapsed;

	assign q_wdata = {in_total, in_cur, in_prev, in_iv, in_elapsed};
	assign {out_total, out_cur, out_prev, out_iv, out_elapsed} = q_rdata;

	evrm_front #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.now_us       (now_us),
		.q_status     (q_status),
		.push         (push),
		.snap_total   (in_total),
		.snap_cur     (in_cur),
		.snap_prev    (in_prev),
		.snap_iv      (in_iv),
		.snap_elapsed (in_elapsed)
	);

	evrm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	evrm_back #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.pop               (pop),
		.snap_total        (out_total),
		.snap_cur          (out_cur),
		.snap_prev         (out_prev),
		.snap_iv           (out_iv),
		.snap_elapsed      (out_elapsed),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.total_count       (total_count),
		.rate_per_interval (rate_per_interval)
	);

endmodule

`default_nettype wire

@@ sv/evrm_queue.sv @@
// Small register queue between the front and the back of the rate meter.
// Depends on evrm_pkg for its depth and status type.
`default_nettype none

module evrm_queue
	import evrm_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output q_status_t             status
);

	logic [WIDTH-1:0]     mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign status.not_empty = (cnt_q != '0);
	assign status.not_full  = (cnt_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign do_push = push && status.not_full;
	assign do_pop  = pop && status.not_empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/evrm_front.sv @@
// Front part of the rate meter: accepts words, keeps the window state and
// the interval register, and queues a snapshot for every read word.
// Depends on evrm_pkg.
`default_nettype none

module evrm_front
	import evrm_pkg::*;
#(
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [IV_BITS-1:0]    cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic                  cmd,
	input  wire logic [TIME_BITS-1:0]  now_us,
	input  wire q_status_t             q_status,
	output logic                       push,
	output logic [TOTAL_BITS-1:0]      snap_total,
	output logic [COUNT_BITS-1:0]      snap_cur,
	output logic [COUNT_BITS-1:0]      snap_prev,
	output logic [IV_BITS-1:0]         snap_iv,
	output logic [TIME_BITS-1:0]       snap_elapsed
);

	logic [IV_BITS-1:0]    iv_q;
	logic [TIME_BITS-1:0]  win_start_q;
	logic [COUNT_BITS-1:0] cur_q;
	logic [COUNT_BITS-1:0] prev_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [TIME_BITS-1:0]  elapsed;
	logic [TIME_BITS-1:0]  iv_ext;
	logic [TIME_BITS-1:0]  two_iv;
	logic                  count_acc;

	assign elapsed    = now_us - win_start_q;
	assign iv_ext     = TIME_BITS'(iv_q);
	assign two_iv     = TIME_BITS'({iv_q, 1'b0});
	assign item_ready = !cmd || q_status.not_full;
	assign push       = item_valid && item_ready && cmd;
	assign count_acc  = item_valid && item_ready && !cmd;

	assign snap_total   = total_q;
	assign snap_cur     = cur_q;
	assign snap_prev    = prev_q;
	assign snap_iv      = iv_q;
	assign snap_elapsed = elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q        <= IV_RESET;
			win_start_q <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			total_q     <= '0;
		end else begin
			if (cfg_we) begin
				iv_q <= cfg_wdata;
			end
			if (count_acc) begin
				if (elapsed > iv_ext) begin
					prev_q      <= (elapsed >= two_iv) ? '0 : cur_q;
					cur_q       <= COUNT_BITS'(1);
					win_start_q <= now_us;
				end else if (cur_q != '1) begin
					cur_q <= cur_q + 1'b1;
				end
				if (total_q != '1) begin
					total_q <= total_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/evrm_back.sv @@
// Back part of the rate meter: takes read snapshots from the queue and works
// out the rate with a shift-add multiplier and a restoring divider.
// Depends on evrm_pkg.
`default_nettype none

module evrm_back
	import evrm_pkg::*;
#(
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire q_status_t             q_status,
	output logic                       pop,
	input  wire logic [TOTAL_BITS-1:0] snap_total,
	input  wire logic [COUNT_BITS-1:0] snap_cur,
	input  wire logic [COUNT_BITS-1:0] snap_prev,
	input  wire logic [IV_BITS-1:0]    snap_iv,
	input  wire logic [TIME_BITS-1:0]  snap_elapsed,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic [TOTAL_BITS-1:0]      total_count,
	output logic [RATE_BITS-1:0]       rate_per_interval
);

	localparam int NB = COUNT_BITS + 1;
	localparam int PW = NB + IV_BITS;
	localparam int DW = IV_BITS + 1;
	localparam int CW = $clog2(PW);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_MUL   = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} back_state_t;

	back_state_t            state_q;
	logic [CW-1:0]          cnt_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic [COUNT_BITS-1:0]  cur_q;
	logic [COUNT_BITS-1:0]  prev_q;
	logic [IV_BITS-1:0]     iv_q;
	logic [TIME_BITS-1:0]   elapsed_q;
	logic [NB-1:0]          n_q;
	logic [DW-1:0]          d_q;
	logic [PW-1:0]          acc_q;
	logic [DW-1:0]          rem_q;
	logic                   out_valid_q;
	logic [TOTAL_BITS-1:0]  total_out_q;
	logic [RATE_BITS-1:0]   rate_out_q;

	logic [TIME_BITS-1:0]   iv_ext;
	logic [TIME_BITS-1:0]   two_iv;
	logic                   past_one;
	logic                   past_two;
	logic [NB-1:0]          n_next;
	logic [DW-1:0]          d_next;
	logic [DW:0]            trial;
	logic                   ge;
	logic [PW-1:0]          addend;
	logic                   out_free;
	logic [RATE_BITS-1:0]   rate_sat;

	assign iv_ext   = TIME_BITS'(iv_q);
	assign two_iv   = TIME_BITS'({iv_q, 1'b0});
	assign past_one = elapsed_q > iv_ext;
	assign past_two = elapsed_q > two_iv;
	assign n_next   = past_one ? NB'(cur_q) : (NB'(cur_q) + NB'(prev_q));
	assign d_next   = past_one ? elapsed_q[DW-1:0]
	                           : (DW'(elapsed_q[IV_BITS-1:0]) + DW'(iv_q));
	assign trial    = {rem_q, acc_q[PW-1]};
	assign ge       = trial >= {1'b0, d_q};
	assign addend   = iv_q[IV_BITS-1] ? PW'(n_q) : '0;
	assign out_free = !out_valid_q || result_ready;
	assign rate_sat = (|acc_q[PW-1:RATE_BITS]) ? '1 : acc_q[RATE_BITS-1:0];
	assign pop      = (state_q == S_IDLE) && q_status.not_empty;

	assign result_valid      = out_valid_q;
	assign total_count       = total_out_q;
	assign rate_per_interval = rate_out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				total_q   <= snap_total;
				cur_q     <= snap_cur;
				prev_q    <= snap_prev;
				iv_q      <= snap_iv;
				elapsed_q <= snap_elapsed;
			end
			S_SETUP: begin
				n_q   <= n_next;
				d_q   <= d_next;
				acc_q <= '0;
				rem_q <= '0;
			end
			S_MUL: begin
				acc_q <= {acc_q[PW-2:0], 1'b0} + addend;
				iv_q  <= {iv_q[IV_BITS-2:0], 1'b0};
			end
			S_DIV: begin
				rem_q <= ge ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
				acc_q <= {acc_q[PW-2:0], ge};
			end
			S_DONE: begin
				if (out_free) begin
					total_out_q <= total_q;
					rate_out_q  <= rate_sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_status.not_empty) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					cnt_q <= '0;
					if (past_two || (d_next == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == CW'(IV_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(PW - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/evrm_checker.sv @@
// Port-level checks for the windowed event rate meter, bound to its top level.
// Depends on evrm_pkg and on the windowed_event_rate_meter ports.
`default_nettype none

module evrm_checker
	import evrm_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  item_valid,
	input wire logic                  item_ready,
	input wire logic                  cmd,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire logic [TOTAL_BITS-1:0] total_count,
	input wire logic [RATE_BITS-1:0]  rate_per_interval
);

	logic [3:0]            pending_q;
	logic [TOTAL_BITS-1:0] last_total_q;
	logic                  read_acc;
	logic                  res_acc;

	assign read_acc = item_valid && item_ready && cmd;
	assign res_acc  = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_total_q <= '0;
		end else begin
			if (read_acc && !res_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (res_acc && !read_acc) begin
				pending_q <= pending_q - 1'b1;
			end
			if (res_acc) begin
				last_total_q <= total_count;
			end
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(total_count) && $stable(rate_per_interval))
		else $error("result word changed while stalled");

	a_result_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("result word without an outstanding read");

	a_stall_needs_reads: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> pending_q != '0)
		else $error("input stalled with no read outstanding");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> total_count >= last_total_q)
		else $error("total count went backwards");

endmodule

bind windowed_event_rate_meter evrm_checker u_evrm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item_valid),
	.item_ready        (item_ready),
	.cmd               (cmd),
	.result_valid      (result_valid),
	.result_ready      (result_ready),
	.total_count       (total_count),
	.rate_per_interval (rate_per_interval)
);

`default_nettype wire
